/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication on the next clock
`define ASSERT_NEXT(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |=> (prop), msg)

`endif

/* hdl/irpw_pkg.sv */
package irpw_pkg;

    localparam int COUNT_BITS = 16;
    // compare width covers both the run counters and the 16-bit registers
    localparam int CMP_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int REG_COUNT  = 5;
    localparam int ADDR_BITS  = $clog2(REG_COUNT) + 2;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CMP_BITS-1:0]   cmp_t;

    localparam count_t CNT_MAX = '1;

    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_DONE  = 3'd1,
        KIND_TRUNC = 3'd2,
        KIND_EMPTY = 3'd3,
        KIND_BAD   = 3'd4
    } kind_t;

    typedef enum logic [ADDR_BITS-3:0] {
        REG_ONE_MIN     = 3'd0,
        REG_ONE_MAX     = 3'd1,
        REG_ZERO_MIN    = 3'd2,
        REG_ZERO_MAX    = 3'd3,
        REG_RUN_TIMEOUT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] one_min;
        logic [15:0] one_max;
        logic [15:0] zero_min;
        logic [15:0] zero_max;
        logic [15:0] run_timeout;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data_byte;
        logic        timeout_cause;
        logic [2:0]  bits_held;
        logic [15:0] pulse_length;
    } result_t;

    function automatic count_t count_up(input count_t c);
        return (c == CNT_MAX) ? c : c + count_t'(1);
    endfunction

    function automatic logic run_expired(input count_t c, input logic [15:0] timeout);
        return (cmp_t'(c) >= cmp_t'(timeout)) || (c == CNT_MAX);
    endfunction

    function automatic logic in_window(input count_t c, input logic [15:0] lo,
                                       input logic [15:0] hi);
        return (cmp_t'(c) >= cmp_t'(lo)) && (cmp_t'(c) <= cmp_t'(hi));
    endfunction

    function automatic logic [15:0] sat_length(input count_t c);
        cmp_t ext;
        ext = cmp_t'(c);
        return (ext > cmp_t'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

endpackage

/* hdl/irpw_channels.sv */
interface irpw_sample_if;
    logic valid;
    logic ready;
    logic rx_level;

    modport source (output valid, output rx_level, input ready);
    modport sink (input valid, input rx_level, output ready);
endinterface

interface irpw_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        timeout_cause;
    logic [2:0]  bits_held;
    logic [15:0] pulse_length;

    modport source (output valid, output kind, output data_byte, output timeout_cause,
                    output bits_held, output pulse_length, input ready);
    modport sink (input valid, input kind, input data_byte, input timeout_cause,
                  input bits_held, input pulse_length, output ready);
endinterface

/* hdl/irpw_cfg.sv */
module irpw_cfg
    import irpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output cfg_t                 cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_min     <= 16'd22;
            cfg_reg.one_max     <= 16'd30;
            cfg_reg.zero_min    <= 16'd12;
            cfg_reg.zero_max    <= 16'd20;
            cfg_reg.run_timeout <= 16'd65000;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ONE_MIN:     cfg_reg.one_min     <= pwdata[15:0];
                REG_ONE_MAX:     cfg_reg.one_max     <= pwdata[15:0];
                REG_ZERO_MIN:    cfg_reg.zero_min    <= pwdata[15:0];
                REG_ZERO_MAX:    cfg_reg.zero_max    <= pwdata[15:0];
                REG_RUN_TIMEOUT: cfg_reg.run_timeout <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ONE_MIN:     prdata = {16'd0, cfg_reg.one_min};
            REG_ONE_MAX:     prdata = {16'd0, cfg_reg.one_max};
            REG_ZERO_MIN:    prdata = {16'd0, cfg_reg.zero_min};
            REG_ZERO_MAX:    prdata = {16'd0, cfg_reg.zero_max};
            REG_RUN_TIMEOUT: prdata = {16'd0, cfg_reg.run_timeout};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/irpw_decode.sv */
module irpw_decode
    import irpw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    level,
    input  cfg_t    cfg,
    output result_t result
);

    logic        in_low_reg, in_low_next;
    count_t      high_run_reg, high_run_next;
    count_t      low_run_reg, low_run_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  byte_shift_reg, byte_shift_next;
    logic        any_pulse_reg, any_pulse_next;

    count_t      count_inc;
    logic        is_one;
    logic        is_zero;
    logic        frame_end;
    logic        cause;
    logic        restart;
    logic [7:0]  shift_new;

    assign count_inc = count_up(in_low_reg ? low_run_reg : high_run_reg);
    assign is_one    = in_window(low_run_reg, cfg.one_min, cfg.one_max);
    assign is_zero   = in_window(low_run_reg, cfg.zero_min, cfg.zero_max);
    assign shift_new = byte_shift_reg | (8'(is_one) << bit_index_reg);

    always_comb
    begin
        in_low_next     = in_low_reg;
        high_run_next   = high_run_reg;
        low_run_next    = low_run_reg;
        bit_index_next  = bit_index_reg;
        byte_shift_next = byte_shift_reg;
        any_pulse_next  = any_pulse_reg;
        result          = '0;
        result.kind     = KIND_BYTE;
        frame_end       = 1'b0;
        cause           = 1'b0;
        restart         = 1'b0;

        if (!in_low_reg)
        begin
            if (level)
            begin
                high_run_next = count_inc;
                frame_end     = run_expired(count_inc, cfg.run_timeout);
            end
            else
            begin
                // falling edge: first low sample already counts
                in_low_next  = 1'b1;
                low_run_next = count_t'(1);
                frame_end    = run_expired(count_t'(1), cfg.run_timeout);
                cause        = 1'b1;
            end
        end
        else if (!level)
        begin
            low_run_next = count_inc;
            frame_end    = run_expired(count_inc, cfg.run_timeout);
            cause        = 1'b1;
        end
        else if (!is_one && !is_zero)
        begin
            result.valid        = 1'b1;
            result.kind         = KIND_BAD;
            result.pulse_length = sat_length(low_run_reg);
            restart             = 1'b1;
        end
        else
        begin
            // rising edge with a good pulse, one window wins on overlap
            in_low_next    = 1'b0;
            high_run_next  = count_t'(1);
            low_run_next   = '0;
            any_pulse_next = 1'b1;
            if (bit_index_reg == 3'd7)
            begin
                result.valid     = 1'b1;
                result.kind      = KIND_BYTE;
                result.data_byte = shift_new;
                byte_shift_next  = '0;
                bit_index_next   = '0;
            end
            else
            begin
                byte_shift_next = shift_new;
                bit_index_next  = bit_index_reg + 3'd1;
            end
        end

        if (frame_end)
        begin
            result.valid         = 1'b1;
            result.timeout_cause = cause;
            restart              = 1'b1;
            if (!any_pulse_reg)
            begin
                result.kind = KIND_EMPTY;
            end
            else if (bit_index_reg != 3'd0)
            begin
                result.kind      = KIND_TRUNC;
                result.bits_held = bit_index_reg;
            end
            else
            begin
                result.kind = KIND_DONE;
            end
        end

        if (restart)
        begin
            in_low_next     = 1'b0;
            high_run_next   = '0;
            low_run_next    = '0;
            bit_index_next  = '0;
            byte_shift_next = '0;
            any_pulse_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_low_reg     <= 1'b0;
            high_run_reg   <= '0;
            low_run_reg    <= '0;
            bit_index_reg  <= '0;
            byte_shift_reg <= '0;
            any_pulse_reg  <= 1'b0;
        end
        else if (step)
        begin
            in_low_reg     <= in_low_next;
            high_run_reg   <= high_run_next;
            low_run_reg    <= low_run_next;
            bit_index_reg  <= bit_index_next;
            byte_shift_reg <= byte_shift_next;
            any_pulse_reg  <= any_pulse_next;
        end
    end

endmodule

/* hdl/ir_pulse_width_receiver.sv */
// path: an accepted sample is held in the sample register, decoded, then put in the result register
// throughput: one sample per cycle, set by the single decode stage between the sample
// register and the result register; a full result register stalls only when it holds
// a result and the decode stage has another one to hand over
// reset: rst_n clears run counters, frame state and both pipeline valid flags at once,
// and loads the window and timeout registers with their defaults
`include "assert_macros.svh"

module ir_pulse_width_receiver
    import irpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    irpw_sample_if.sink          samples,
    irpw_result_if.source        results,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    cfg_t    cfg;
    result_t result;
    result_t out_reg;
    logic    in_vld_reg;
    logic    level_reg;
    logic    out_free;
    logic    advance;

    assign pready = 1'b1;

    irpw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    irpw_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .level  (level_reg),
        .cfg    (cfg),
        .result (result)
    );

    // the result slot frees up in the same cycle it is taken
    assign out_free      = !out_reg.valid || results.ready;
    assign advance       = in_vld_reg && (!result.valid || out_free);
    assign samples.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_vld_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            level_reg <= samples.rx_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (advance && result.valid)
        begin
            out_reg <= result;
        end
        else if (results.ready)
        begin
            out_reg.valid <= 1'b0;
        end
    end

    assign results.valid         = out_reg.valid;
    assign results.kind          = out_reg.kind;
    assign results.data_byte     = out_reg.data_byte;
    assign results.timeout_cause = out_reg.timeout_cause;
    assign results.bits_held     = out_reg.bits_held;
    assign results.pulse_length  = out_reg.pulse_length;

    `ASSERT_NEXT(a_result_loaded, advance && result.valid, out_reg.valid,
                 "decoded result not loaded into result register")
    `ASSERT_NEXT(a_sample_held, in_vld_reg && !advance, in_vld_reg && $stable(level_reg),
                 "stalled sample lost or changed")
    `ASSERT_NEXT(a_accept_fills, samples.valid && samples.ready, in_vld_reg,
                 "accepted transaction not captured")
    `ASSERT_CLK(a_bits_held_kind,
                results.valid && results.kind != KIND_TRUNC |-> results.bits_held == 3'd0,
                "bits_held set outside a truncated frame")

endmodule
